// ----- rtl/shfr_pkg.sv -----
package shfr_pkg;

  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [8:0]  SUM_MOD       = 9'd255;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam int          QUEUE_DEPTH   = 2;

  localparam logic [1:0] K_PAYLOAD = 2'd0;
  localparam logic [1:0] K_OK      = 2'd1;
  localparam logic [1:0] K_BAD_SUM = 2'd2;
  localparam logic [1:0] K_TIMEOUT = 2'd3;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_SYNC,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } q_item_t;

endpackage

// ----- rtl/shfr_in_if.sv -----
interface shfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

// ----- rtl/shfr_out_if.sv -----
interface shfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [7:0]  sender_id;
  logic [7:0]  receiver_id;
  logic [15:0] frame_length;

  modport source (output valid, output kind, output payload_byte, output sender_id,
                  output receiver_id, output frame_length, input ready);
  modport sink (input valid, input kind, input payload_byte, input sender_id,
                input receiver_id, input frame_length, output ready);
endinterface

// ----- rtl/shfr_front.sv -----
module shfr_front (
  input  logic             clk,
  input  logic             rst_n,
  shfr_in_if.sink          in_ch,
  output logic             f_valid,
  output shfr_pkg::q_item_t f_item,
  input  logic             q_ready
);
  import shfr_pkg::*;

  logic    f_valid_r, f_valid_nxt;
  q_item_t f_item_r, f_item_nxt;
  logic    take;

  assign in_ch.ready = !f_valid_r || q_ready;
  assign take        = in_ch.valid && in_ch.ready;

  // classify the word: tick, sync byte or plain byte
  always_comb begin
    f_valid_nxt = f_valid_r && !q_ready;
    f_item_nxt  = f_item_r;
    if (take) begin
      f_valid_nxt     = 1'b1;
      f_item_nxt.data = in_ch.rx_byte;
      if (in_ch.command) begin
        f_item_nxt.op = OP_TICK;
      end else if (in_ch.rx_byte == SYNC_BYTE) begin
        f_item_nxt.op = OP_SYNC;
      end else begin
        f_item_nxt.op = OP_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    f_item_r <= f_item_nxt;
  end

  assign f_valid = f_valid_r;
  assign f_item  = f_item_r;
endmodule

// ----- rtl/shfr_queue.sv -----
module shfr_queue #(
  parameter int QDEPTH = shfr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  shfr_pkg::q_item_t push_item,
  output logic              push_ready,
  output logic              pop_valid,
  output shfr_pkg::q_item_t pop_item,
  input  logic              pop
);
  import shfr_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  q_item_t       mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end
endmodule

// ----- rtl/shfr_back.sv -----
module shfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  shfr_pkg::q_item_t q_item,
  output logic              q_pop,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  shfr_out_if.source        out_ch
);
  import shfr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_HEAD  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CSUM  = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr_r [4];
  logic [7:0]  hdr_nxt [4];
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [15:0] pcnt_r, pcnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] tcnt_r, tcnt_nxt;
  logic [15:0] tmo_r;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic [7:0]  snd_r, snd_nxt;
  logic [7:0]  rcv_r, rcv_nxt;
  logic [15:0] len_r, len_nxt;

  logic        emit;
  logic [1:0]  ekind;
  logic [7:0]  ebyte;
  logic [8:0]  sum_add;
  logic [7:0]  sum_mod;
  logic [15:0] tick_cnt;
  logic [15:0] pcnt_inc;

  assign q_pop    = q_valid && (!out_valid_r || out_ch.ready);
  assign sum_add  = {1'b0, sum_r} + {1'b0, q_item.data};
  assign sum_mod  = (sum_add >= SUM_MOD) ? 8'(sum_add - SUM_MOD) : sum_add[7:0];
  assign tick_cnt = tcnt_r + 16'd1;
  assign pcnt_inc = pcnt_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    hcnt_nxt  = hcnt_r;
    pcnt_nxt  = pcnt_r;
    sum_nxt   = sum_r;
    armed_nxt = armed_r;
    tcnt_nxt  = tcnt_r;
    emit      = 1'b0;
    ekind     = K_PAYLOAD;
    ebyte     = 8'd0;
    if (q_pop) begin
      if (q_item.op == OP_TICK) begin
        if (armed_r) begin
          tcnt_nxt = tick_cnt;
          if (!(tick_cnt < tmo_r)) begin
            armed_nxt = 1'b0;
            if (phase_r != PH_IDLE) begin
              phase_nxt = PH_IDLE;
              emit      = 1'b1;
              ekind     = K_TIMEOUT;
            end
          end
        end
      end else begin
        case (phase_r)
          PH_IDLE: begin
            if (q_item.op == OP_SYNC) begin
              phase_nxt = PH_SYNC2;
              armed_nxt = 1'b1;
              tcnt_nxt  = 16'd0;
            end
          end
          PH_SYNC2: begin
            if (q_item.op == OP_SYNC) begin
              hcnt_nxt  = 2'd0;
              sum_nxt   = 8'd0;
              phase_nxt = PH_HEAD;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_HEAD: begin
            hdr_nxt[hcnt_r] = q_item.data;
            sum_nxt         = sum_mod;
            if (hcnt_r == 2'd3) begin
              hcnt_nxt  = 2'd0;
              pcnt_nxt  = 16'd0;
              phase_nxt = ({hdr_r[2], q_item.data} != 16'd0) ? PH_DATA : PH_IDLE;
            end else begin
              hcnt_nxt = hcnt_r + 2'd1;
            end
          end
          PH_DATA: begin
            sum_nxt  = sum_mod;
            pcnt_nxt = pcnt_inc;
            if (pcnt_inc >= {hdr_r[2], hdr_r[3]}) begin
              phase_nxt = PH_CSUM;
            end
            emit  = 1'b1;
            ekind = K_PAYLOAD;
            ebyte = q_item.data;
          end
          PH_CSUM: begin
            armed_nxt = 1'b0;
            tcnt_nxt  = 16'd0;
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            ekind     = (sum_r == q_item.data) ? K_OK : K_BAD_SUM;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // output register, refilled as the word is taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    pbyte_nxt     = pbyte_r;
    snd_nxt       = snd_r;
    rcv_nxt       = rcv_r;
    len_nxt       = len_r;
    if (q_pop) begin
      out_valid_nxt = emit;
      if (emit) begin
        kind_nxt  = ekind;
        pbyte_nxt = ebyte;
        snd_nxt   = hdr_r[0];
        rcv_nxt   = hdr_r[1];
        len_nxt   = {hdr_r[2], hdr_r[3]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hdr_r       <= '{default: 8'd0};
      hcnt_r      <= 2'd0;
      pcnt_r      <= 16'd0;
      sum_r       <= 8'd0;
      armed_r     <= 1'b0;
      tcnt_r      <= 16'd0;
      tmo_r       <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_r       <= hdr_nxt;
      hcnt_r      <= hcnt_nxt;
      pcnt_r      <= pcnt_nxt;
      sum_r       <= sum_nxt;
      armed_r     <= armed_nxt;
      tcnt_r      <= tcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tmo_r <= cfg_wdata;
      end
    end
    kind_r  <= kind_nxt;
    pbyte_r <= pbyte_nxt;
    snd_r   <= snd_nxt;
    rcv_r   <= rcv_nxt;
    len_r   <= len_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.payload_byte = pbyte_r;
  assign out_ch.sender_id    = snd_r;
  assign out_ch.receiver_id  = rcv_r;
  assign out_ch.frame_length = len_r;
endmodule

// ----- rtl/sync_header_frame_receiver.sv -----
// channel   dir  handshake      words
// in_ch     in   valid/ready    command, rx_byte
// out_ch    out  valid/ready    kind, payload_byte, sender_id, receiver_id, frame_length
// cfg       in   cfg_we         cfg_wdata (timeout_ticks)
//
// one word accepted per cycle unless a full queue holds the front register; a result passes
// through the front register, queue and output register in turn; the parser step sets the rate
// synchronous active-low reset clears parser, timer and queue; timeout back to 3000 ticks
// a stalled output fills the queue, then the front stops taking words
module sync_header_frame_receiver #(
  parameter int QDEPTH = shfr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  shfr_in_if.sink     in_ch,
  shfr_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import shfr_pkg::*;

  logic    f_valid, q_ready, q_valid, q_pop;
  q_item_t f_item, q_item;

  shfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .f_valid (f_valid),
    .f_item  (f_item),
    .q_ready (q_ready)
  );

  shfr_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_item  (f_item),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  shfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

  a_no_out_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_ch.valid)
    else $error("result word straight after reset");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind != K_PAYLOAD) |-> out_ch.payload_byte == 8'd0)
    else $error("payload byte set on a frame status word");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !out_ch.valid) |-> q_pop)
    else $error("queue held while output register empty");
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import shfr_pkg::*;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int CS_GOOD  = 0;
  localparam int CS_WRONG = 1;
  localparam int CS_FF    = 2;
  localparam int CS_TRUNC = 3;

  localparam int MAX_WAIT      = 13;
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_LIMIT  = 10;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_WORDS   = 225;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECKSUM
  } rx_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  sender_id;
    logic [7:0]  receiver_id;
    logic [15:0] frame_length;
  } frame_event_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  shfr_in_if  in_ch ();
  shfr_out_if out_ch ();

  sync_header_frame_receiver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  frame_event_t expected_events[$];
  frame_event_t got_event;
  frame_event_t want_event;
  int error_count = 0;
  int words_sent  = 0;
  int cycle_count = 0;
  int ready_hold  = 0;
  bit quiet       = 1'b0;

  // predicted receiver state
  rx_phase_e   rx_phase   = PH_SYNC1;
  logic [7:0]  hdr [4]    = '{default: 8'h00};
  logic [1:0]  hdr_idx    = 2'd0;
  logic [15:0] data_count = 16'd0;
  logic [7:0]  sum        = 8'd0;
  bit          tmr_armed  = 1'b0;
  logic [15:0] tmr_count  = 16'd0;
  logic [15:0] tmr_limit  = TIMEOUT_RESET;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [7:0] add_mod255(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, b};
    if (s >= SUM_MOD) s = s - SUM_MOD;
    return s[7:0];
  endfunction

  function automatic frame_event_t make_event(input logic [1:0] kind, input logic [7:0] pb);
    frame_event_t ev;
    ev.kind         = kind;
    ev.payload_byte = pb;
    ev.sender_id    = hdr[0];
    ev.receiver_id  = hdr[1];
    ev.frame_length = {hdr[2], hdr[3]};
    return ev;
  endfunction

  task automatic predict_word(input logic cmd, input logic [7:0] b);
    if (cmd == CMD_TICK) begin
      if (tmr_armed) begin
        tmr_count = tmr_count + 16'd1;
        if (tmr_count >= tmr_limit) begin
          tmr_armed = 1'b0;
          if (rx_phase != PH_SYNC1) begin
            rx_phase = PH_SYNC1;
            expected_events.push_back(make_event(K_TIMEOUT, 8'h00));
          end
        end
      end
    end else begin
      case (rx_phase)
        PH_SYNC1: begin
          if (b == SYNC_BYTE) begin
            rx_phase  = PH_SYNC2;
            tmr_armed = 1'b1;
            tmr_count = 16'd0;
          end
        end
        PH_SYNC2: begin
          if (b == SYNC_BYTE) begin
            hdr_idx  = 2'd0;
            sum      = 8'd0;
            rx_phase = PH_HEADER;
          end else begin
            rx_phase = PH_SYNC1;
          end
        end
        PH_HEADER: begin
          hdr[hdr_idx] = b;
          sum = add_mod255(sum, b);
          if (hdr_idx == 2'd3) begin
            hdr_idx    = 2'd0;
            data_count = 16'd0;
            rx_phase   = ({hdr[2], hdr[3]} != 16'd0) ? PH_PAYLOAD : PH_SYNC1;
          end else begin
            hdr_idx = hdr_idx + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          sum = add_mod255(sum, b);
          data_count = data_count + 16'd1;
          if (data_count >= {hdr[2], hdr[3]}) rx_phase = PH_CHECKSUM;
          expected_events.push_back(make_event(K_PAYLOAD, b));
        end
        PH_CHECKSUM: begin
          tmr_armed = 1'b0;
          tmr_count = 16'd0;
          rx_phase  = PH_SYNC1;
          expected_events.push_back(make_event((sum == b) ? K_OK : K_BAD_SUM, 8'h00));
        end
        default: rx_phase = PH_SYNC1;
      endcase
    end
  endtask

  // result sink: random stall after each word, none while quiet
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        out_ch.ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_event = '{out_ch.kind, out_ch.payload_byte, out_ch.sender_id,
                    out_ch.receiver_id, out_ch.frame_length};
      if (expected_events.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected word: kind %0d byte %02h src %02h dst %02h len %0d",
                   got_event.kind, got_event.payload_byte, got_event.sender_id,
                   got_event.receiver_id, got_event.frame_length);
      end else begin
        want_event = expected_events.pop_front();
        if (got_event.kind !== want_event.kind ||
            got_event.payload_byte !== want_event.payload_byte ||
            got_event.sender_id !== want_event.sender_id ||
            got_event.receiver_id !== want_event.receiver_id ||
            got_event.frame_length !== want_event.frame_length) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("mismatch: expected kind %0d byte %02h src %02h dst %02h len %0d, got kind %0d byte %02h src %02h dst %02h len %0d",
                     want_event.kind, want_event.payload_byte, want_event.sender_id,
                     want_event.receiver_id, want_event.frame_length,
                     got_event.kind, got_event.payload_byte, got_event.sender_id,
                     got_event.receiver_id, got_event.frame_length);
        end
      end
      ready_hold = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  task automatic send_word(input logic cmd, input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(cmd, b);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] ticks);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tmr_limit = ticks;
  endtask

  task automatic maybe_tick(input int tick_pct);
    if (tick_pct > 0 && $urandom_range(0, 99) < tick_pct)
      send_word(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                            input logic [15:0] len, input int cs_mode, input int tick_pct);
    logic [7:0] head [4];
    logic [7:0] acc;
    logic [7:0] b;
    int i;
    head = '{src, dst, len[15:8], len[7:0]};
    acc = 8'd0;
    send_word(CMD_BYTE, SYNC_BYTE);
    maybe_tick(tick_pct);
    send_word(CMD_BYTE, SYNC_BYTE);
    for (i = 0; i < 4; i++) begin
      maybe_tick(tick_pct);
      send_word(CMD_BYTE, head[i]);
      acc = add_mod255(acc, head[i]);
    end
    if (len == 16'd0) return;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      maybe_tick(tick_pct);
      send_word(CMD_BYTE, b);
      acc = add_mod255(acc, b);
    end
    if (cs_mode == CS_TRUNC) return;
    case (cs_mode)
      CS_WRONG: begin
        b = 8'($urandom_range(0, 255));
        if (b == acc) b = b + 8'd1;
      end
      CS_FF:   b = SYNC_BYTE;
      default: b = acc;
    endcase
    maybe_tick(tick_pct);
    send_word(CMD_BYTE, b);
  endtask

  task automatic test_frame_paths();
    send_word(CMD_TICK, 8'h00);
    send_frame(8'h12, 8'h34, 16'd2, CS_GOOD, 0);
    send_frame(8'hFF, 8'h00, 16'd1, CS_FF, 0);
    send_frame(8'h01, 8'h02, 16'd0, CS_GOOD, 0);
    // second byte not sync, then a fresh sync while still armed
    send_word(CMD_BYTE, SYNC_BYTE);
    send_word(CMD_BYTE, 8'h00);
    send_frame(8'hA5, 8'h5A, 16'd3, CS_WRONG, 0);
  endtask

  task automatic test_timer_expiry();
    set_timeout(16'd1);
    send_word(CMD_BYTE, SYNC_BYTE);
    send_word(CMD_TICK, 8'hFF);
    send_frame(8'h00, 8'hFF, 16'd2, CS_TRUNC, 0);
    send_word(CMD_TICK, 8'h00);
    // expiry while idle, then a tick with the timer off
    send_word(CMD_BYTE, SYNC_BYTE);
    send_word(CMD_BYTE, 8'h7E);
    send_word(CMD_TICK, 8'h00);
    send_word(CMD_TICK, 8'h00);
    set_timeout(16'd0);
    send_word(CMD_BYTE, SYNC_BYTE);
    send_word(CMD_BYTE, SYNC_BYTE);
    send_word(CMD_TICK, 8'h00);
    set_timeout(16'd3);
    send_word(CMD_BYTE, SYNC_BYTE);
    send_word(CMD_BYTE, SYNC_BYTE);
    send_word(CMD_BYTE, 8'h81);
    repeat (3) send_word(CMD_TICK, 8'h00);
  endtask

  task automatic test_random_traffic();
    int p;
    int target;
    int sel;
    int r;
    int cs_mode;
    int tick_pct;
    logic [15:0] ticks;
    logic [15:0] len;
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       ticks = 16'hFFFF;
        1:       ticks = 16'($urandom_range(2, 40));
        2:       ticks = 16'd0;
        3:       ticks = TIMEOUT_RESET;
        4:       ticks = 16'($urandom_range(40, 400));
        default: ticks = 16'd1;
      endcase
      set_timeout(ticks);
      tick_pct = (ticks <= 16'd40) ? 3 : 15;
      quiet = (p == 3);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          r = $urandom_range(0, 99);
          if (r < 8) len = 16'd0;
          else if (r < 96) len = 16'($urandom_range(1, 12));
          else len = 16'($urandom_range(13, 600));
          r = $urandom_range(0, 9);
          cs_mode = (r < 7) ? CS_GOOD : (r == 7) ? CS_WRONG : (r == 8) ? CS_FF : CS_TRUNC;
          send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                     cs_mode, tick_pct);
        end else if (sel < 80) begin
          send_word(CMD_BYTE, ($urandom_range(0, 3) == 0) ? SYNC_BYTE
                                                         : 8'($urandom_range(0, 255)));
        end else if (sel < 93) begin
          repeat ($urandom_range(1, 8)) send_word(CMD_TICK, 8'($urandom_range(0, 255)));
        end else begin
          send_word(CMD_BYTE, SYNC_BYTE);
          send_word(CMD_BYTE, 8'($urandom_range(0, 254)));
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 16'd0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_BYTE;
    in_ch.rx_byte = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_frame_paths();
    test_timer_expiry();
    test_random_traffic();
    drain_results();
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
